[design/prefixed_scancode_translator_top_macros.svh]
// assertion macros for the scancode translator modules; pst_queue is the module that uses them
// needs a signal named clock and a signal named reset in the module that uses them
`ifndef PREFIXED_SCANCODE_TRANSLATOR_TOP_MACROS_SVH
`define PREFIXED_SCANCODE_TRANSLATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pst_pkg.sv]
// types, constants and translation tables of the prefixed scancode translator
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

   // low seven bits of the prefix bytes (bit 7 is the key-up mark)
   localparam logic [6:0] PREFIX_SINGLE = 7'h79;
   localparam logic [6:0] PREFIX_DOUBLE = 7'h71;

   // sequence phase of the front end
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_P79   = 2'd1,
      PH_P71   = 2'd2,
      PH_P7179 = 2'd3
   } phase_type;

   // how the back end turns a queued key code into a key id
   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DOUBLE = 2'd2
   } kind_type;

   // one queued beat between front and back
   typedef struct packed {
      kind_type   kind;
      logic [5:0] scan_code;
      logic       pressed;
   } entry_type;

   // key codes after a single prefix; zero means unmapped
   function automatic logic [6:0] single_map(input logic [5:0] kc);
      logic [6:0] id;
      case (kc)
         6'h03: id = 7'h12;
         6'h05: id = 7'h28;
         6'h0D: id = 7'h20;
         6'h11: id = 7'h18;
         6'h19: id = 7'h1A;
         6'h1B: id = 7'h10;
         6'h1D: id = 7'h22;
         6'h25: id = 7'h30;
         6'h27: id = 7'h38;
         6'h29: id = 7'h40;
         6'h2B: id = 7'h48;
         6'h2D: id = 7'h50;
         6'h2F: id = 7'h58;
         6'h31: id = 7'h60;
         6'h33: id = 7'h68;
         6'h37: id = 7'h70;
         6'h39: id = 7'h78;
         default: id = 7'h00;
      endcase
      return id;
   endfunction

   // key codes after the double prefix; zero means unmapped
   function automatic logic [6:0] double_map(input logic [5:0] kc);
      logic [6:0] id;
      case (kc)
         6'h05: id = 7'h42;
         6'h0D: id = 7'h4A;
         6'h0F: id = 7'h2A;
         6'h11: id = 7'h32;
         6'h1B: id = 7'h3A;
         default: id = 7'h00;
      endcase
      return id;
   endfunction

endpackage

[design/prefixed_scancode_translator_top.sv]
// a result passes through the queue and then the result register before it is on the rsp ports
// throughput: one byte per cycle while req_full is low; the front decides each byte from its phase register
// and the QUEUE_DEPTH-entry queue plus one result register absorb result-side stalls
// reset: synchronous, clears the sequence phase, queue pointers and result valid
// top level of the prefixed scancode translator; depends on pst_pkg and its submodules
`timescale 1ns / 1ps

module prefixed_scancode_translator_top import pst_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_raw_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [6:0] rsp_key_id,
   output logic       rsp_pressed
);

   logic      queue_full;
   logic      queue_push;
   entry_type push_entry;
   logic      queue_empty;
   logic      queue_pop;
   entry_type pop_entry;

   // sequence tracking and classification
   pst_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_raw_byte (req_raw_byte),
      .req_full     (req_full),
      .queue_full   (queue_full),
      .queue_push   (queue_push),
      .queue_entry  (push_entry)
   );

   // decoupling queue
   pst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   // translation and result register
   pst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_key_id  (rsp_key_id),
      .rsp_pressed (rsp_pressed)
   );

endmodule

[design/pst_front.sv]
// front end: accepts raw bytes, tracks the prefix sequence, queues key codes
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_front import pst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_raw_byte,
   output logic       req_full,
   input  logic       queue_full,
   output logic       queue_push,
   output entry_type  queue_entry
);

   phase_type  phase_ff;
   phase_type  phase_in;
   logic       accept;
   logic       byte_valid;
   logic       is_single;
   logic       is_double;
   logic [5:0] scan_code;

   // byte decode
   assign req_full   = queue_full;
   assign accept     = req_push && !queue_full;
   assign byte_valid = req_raw_byte[0];
   assign scan_code  = req_raw_byte[6:1];
   assign is_single  = (req_raw_byte[6:0] == PREFIX_SINGLE);
   assign is_double  = (req_raw_byte[6:0] == PREFIX_DOUBLE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (!byte_valid) begin
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (is_single) begin
                     phase_in = PH_P79;
                  end else if (is_double) begin
                     phase_in = PH_P71;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_P71:  phase_in = is_single ? PH_P7179 : PH_IDLE;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // queue beat for bytes that can give a result
   always_comb begin
      queue_push            = 1'b0;
      queue_entry.kind      = KIND_DIRECT;
      queue_entry.scan_code = scan_code;
      queue_entry.pressed   = ~req_raw_byte[7];
      case (phase_ff)
         PH_IDLE: begin
            queue_push = accept && byte_valid && !is_single && !is_double
                         && (scan_code != 6'd0);
         end
         PH_P79: begin
            queue_push       = accept && byte_valid;
            queue_entry.kind = KIND_SINGLE;
         end
         PH_P7179: begin
            queue_push       = accept && byte_valid;
            queue_entry.kind = KIND_DOUBLE;
         end
         default: queue_push = 1'b0;
      endcase
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

[design/pst_queue.sv]
// short register queue between front and back end
// depends on pst_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "prefixed_scancode_translator_top_macros.svh"

module pst_queue import pst_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            wr_en;
   logic            rd_en;

   // flags and enables
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign wr_en     = push && !full;
   assign rd_en     = pop && !empty;
   assign pop_entry = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // checks
   `PST_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `PST_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1, "queue count did not rise")
   `PST_ASSERT_NEXT(a_count_down, rd_en && !wr_en, count_ff == $past(count_ff) - 1'b1, "queue count did not fall")
   `PST_ASSERT_NOW(a_ptr_gap, !full && !empty, wr_ptr_ff != rd_ptr_ff, "queue pointers meet while partly filled")

endmodule

[design/pst_back.sv]
// back end: translates queued key codes and holds the result register
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_back import pst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  entry_type  queue_entry,
   output logic       queue_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [6:0] rsp_key_id,
   output logic       rsp_pressed
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [6:0] key_id_ff;
   logic       pressed_ff;
   logic [6:0] lookup_id;

   // take a beat when the result register is free or being emptied
   assign queue_pop = !queue_empty && (!out_valid_ff || rsp_pop);

   // translation
   always_comb begin
      case (queue_entry.kind)
         KIND_DIRECT: lookup_id = {1'b0, queue_entry.scan_code};
         KIND_SINGLE: lookup_id = single_map(queue_entry.scan_code);
         KIND_DOUBLE: lookup_id = double_map(queue_entry.scan_code);
         default:     lookup_id = 7'h00;
      endcase
   end

   // unmapped codes are dropped here
   always_comb begin
      out_valid_in = out_valid_ff;
      if (queue_pop) begin
         out_valid_in = (lookup_id != 7'h00);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         key_id_ff  <= lookup_id;
         pressed_ff <= queue_entry.pressed;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_key_id  = key_id_ff;
   assign rsp_pressed = pressed_ff;

endmodule
